// ===== hw/rtl/vc1_seq_header_extractor_defines.svh =====
// Assertion macros for the VC-1 sequence-header extractor.
// Included by the RTL files that carry assertions; no other dependencies.
`ifndef VC1_SEQ_HEADER_EXTRACTOR_DEFINES_SVH
`define VC1_SEQ_HEADER_EXTRACTOR_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold on every clock edge outside reset
`define VSH_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("vsh assertion failed");
// expression must never be true outside reset
`define VSH_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("vsh forbidden condition seen");
`else
`define VSH_ASSERT(lbl, clk, rst, prop)
`define VSH_NEVER(lbl, clk, rst, expr)
`endif

`endif

// ===== hw/rtl/vsh_pkg.sv =====
// Shared types and constants for the VC-1 sequence-header extractor.
// No dependencies.
package vsh_pkg;

   localparam int CSR_W          = 16;
   localparam int CNT_W          = 6;   // held-zero / zero-burst counter width
   localparam int ZERO_HOLD_DEF  = 63;
   localparam int HOLD_LIMIT     = 62;  // keeps one beat burst at 64 results
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic REG_MAX_LEN     = 1'b0;
   localparam logic REG_HEADER_CODE = 1'b1;

   localparam logic [15:0] MAX_LEN_RST     = 16'd1024;
   localparam logic [7:0]  HEADER_CODE_RST = 8'h0F;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_DONE = 2'd1,
      KIND_MORE = 2'd2,
      KIND_OVF  = 2'd3
   } kind_type;

   // one command: zero burst, up to two literal bytes, optional end marker
   typedef struct packed {
      logic [CNT_W-1:0] zeros;
      logic             t0_vld;
      logic [7:0]       t0;
      logic             t1_vld;
      logic [7:0]       t1;
      logic             end_vld;
      kind_type         end_kind;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_stat_type;

endpackage

// ===== hw/rtl/vc1_seq_header_extractor.sv =====
// Top level of the VC-1 sequence-header extractor.
// Instantiates vsh_front, vsh_cmd_fifo and vsh_back; uses vsh_pkg.
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+-------------------------------------
//   req     | in  | req_valid/req_stall | data_byte, end_of_data, stream_complete
//   rsp     | out | rsp_valid/rsp_stall | out_kind, out_byte, last_of_run
//   csr     | in  | csr_wr_en           | csr_index, csr_wdata (no read-back)
//
// A byte beat is taken whenever the command queue has room; the front end
// scans, holds zeros and checks length in that same cycle.
// The back end loads a beat's command from the queue, then gives one result
// per cycle while the output register is free; a held zero run flush of up
// to 62 zeros sets the longest burst at 64 results.
// Beats that yield no result never enter the queue.
// Reset is synchronous and clears scan state, queue and output valid.
// rsp_stall holds the output register; req_stall rises only when the queue
// is full, so input keeps flowing while results wait.

module vc1_seq_header_extractor #(
   parameter int ZERO_HOLD   = vsh_pkg::ZERO_HOLD_DEF,
   parameter int QUEUE_DEPTH = vsh_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic                      csr_index,
   input  logic [vsh_pkg::CSR_W-1:0] csr_wdata,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_end_of_data,
   input  logic                      req_stream_complete,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_out_kind,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_last_of_run
);

   vsh_pkg::cmd_type       push_cmd;
   vsh_pkg::cmd_type       head_cmd;
   vsh_pkg::fifo_stat_type q_stat;
   logic                   push;
   logic                   pop;
   logic                   accept;

   // stall on a full queue: a beat may always produce a command
   assign req_stall = q_stat.full;
   assign accept    = req_valid && !q_stat.full;

   vsh_front #(
      .ZERO_HOLD (ZERO_HOLD)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .data_byte       (req_data_byte),
      .end_of_data     (req_end_of_data),
      .stream_complete (req_stream_complete),
      .accept          (accept),
      .push            (push),
      .cmd             (push_cmd)
   );

   vsh_cmd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (push_cmd),
      .pop     (pop),
      .rd_data (head_cmd),
      .stat    (q_stat)
   );

   vsh_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_data          (head_cmd),
      .q_stat          (q_stat),
      .q_pop           (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ===== hw/rtl/vsh_front.sv =====
// Front end: config registers, start-code scan, zero holding, overflow check.
// Turns each accepted beat into a command for the back end. Uses vsh_pkg.
`include "vc1_seq_header_extractor_defines.svh"

module vsh_front #(
   parameter int ZERO_HOLD = vsh_pkg::ZERO_HOLD_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic                     csr_index,
   input  logic [vsh_pkg::CSR_W-1:0] csr_wdata,
   input  logic                     req_valid,
   input  logic [7:0]               data_byte,
   input  logic                     end_of_data,
   input  logic                     stream_complete,
   input  logic                     accept,
   output logic                     push,
   output vsh_pkg::cmd_type         cmd
);

   localparam int HOLD_CAP = (ZERO_HOLD < vsh_pkg::HOLD_LIMIT) ? ZERO_HOLD
                                                               : vsh_pkg::HOLD_LIMIT;
   localparam int CW = vsh_pkg::CNT_W;

   typedef enum logic [2:0] {
      PH_SEARCH = 3'b001,
      PH_CODE   = 3'b010,
      PH_UNIT   = 3'b100
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [15:0]       win_ff, win_in;
   logic [CW-1:0]     held_ff, held_in;
   logic [15:0]       emit_ff, emit_in;
   logic [15:0]       max_len_ff;
   logic [7:0]        hdr_code_ff;

   vsh_pkg::cmd_type  raw;
   phase_type         tgt_phase;
   logic [15:0]       tgt_win;
   logic [CW-1:0]     tgt_held;
   logic [15:0]       base_cnt;
   logic              chk_eod;
   logic              pair;
   logic [15:0]       shifted;
   logic [CW:0]       k;
   logic [15:0]       room;
   logic              ovf;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff  <= vsh_pkg::MAX_LEN_RST;
         hdr_code_ff <= vsh_pkg::HEADER_CODE_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            vsh_pkg::REG_MAX_LEN:     max_len_ff  <= csr_wdata;
            vsh_pkg::REG_HEADER_CODE: hdr_code_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign pair    = (win_ff == 16'h0000);
   assign shifted = {win_ff[7:0], data_byte};

   always_comb begin
      raw          = '0;
      raw.end_kind = vsh_pkg::KIND_DONE;
      tgt_phase    = phase_ff;
      tgt_win      = shifted;
      tgt_held     = held_ff;
      base_cnt     = emit_ff;
      chk_eod      = 1'b0;
      case (phase_ff)
         PH_UNIT: begin
            if (pair && data_byte == 8'h01) begin
               // next start code: drop held zeros, close unit, await suffix
               raw.end_vld  = 1'b1;
               raw.end_kind = vsh_pkg::KIND_DONE;
               tgt_phase    = PH_CODE;
               tgt_win      = 16'h0001;
               tgt_held     = '0;
               base_cnt     = '0;
            end else begin
               chk_eod = 1'b1;
               if (pair && data_byte == 8'h03) begin
                  // emulation prevention byte: flush zeros, drop the 03
                  raw.zeros = held_ff;
                  tgt_held  = '0;
               end else if (data_byte == 8'h00) begin
                  if (held_ff >= CW'(HOLD_CAP)) begin
                     raw.zeros = CW'(1);
                  end else begin
                     tgt_held = held_ff + CW'(1);
                  end
               end else begin
                  raw.zeros  = held_ff;
                  raw.t0_vld = 1'b1;
                  raw.t0     = data_byte;
                  tgt_held   = '0;
               end
            end
         end
         PH_CODE: begin
            tgt_win = {8'h01, data_byte};
            if (data_byte == hdr_code_ff) begin
               raw.zeros  = CW'(2);
               raw.t0_vld = 1'b1;
               raw.t0     = 8'h01;
               raw.t1_vld = 1'b1;
               raw.t1     = data_byte;
               tgt_phase  = PH_UNIT;
               tgt_held   = '0;
               base_cnt   = '0;
               chk_eod    = 1'b1;
            end else begin
               tgt_phase    = PH_SEARCH;
               raw.end_vld  = end_of_data;
               raw.end_kind = vsh_pkg::KIND_MORE;
            end
         end
         default: begin
            tgt_phase    = (pair && data_byte == 8'h01) ? PH_CODE : PH_SEARCH;
            raw.end_vld  = end_of_data;
            raw.end_kind = vsh_pkg::KIND_MORE;
         end
      endcase
   end

   assign k    = {1'b0, raw.zeros} + {{CW{1'b0}}, raw.t0_vld} + {{CW{1'b0}}, raw.t1_vld};
   assign room = (base_cnt >= max_len_ff) ? 16'd0 : (max_len_ff - base_cnt);
   assign ovf  = {{(16-CW-1){1'b0}}, k} > room;

   always_comb begin
      cmd      = raw;
      phase_in = tgt_phase;
      win_in   = tgt_win;
      held_in  = tgt_held;
      emit_in  = base_cnt + {{(16-CW-1){1'b0}}, k};
      if (ovf) begin
         // room < k <= 64, so room fits the zero counter here
         cmd.zeros    = (room < {{(16-CW){1'b0}}, raw.zeros}) ? room[CW-1:0] : raw.zeros;
         cmd.t0_vld   = raw.t0_vld && (room > {{(16-CW){1'b0}}, raw.zeros});
         cmd.t1_vld   = 1'b0;
         cmd.end_vld  = 1'b1;
         cmd.end_kind = vsh_pkg::KIND_OVF;
         phase_in     = PH_SEARCH;
         win_in       = 16'hFFFF;
         held_in      = '0;
         emit_in      = '0;
      end else if (chk_eod && end_of_data) begin
         cmd.end_vld = 1'b1;
         if (stream_complete) begin
            cmd.end_kind = vsh_pkg::KIND_DONE;
            phase_in     = PH_SEARCH;
            win_in       = 16'hFFFF;
            held_in      = '0;
            emit_in      = '0;
         end else begin
            cmd.end_kind = vsh_pkg::KIND_MORE;
         end
      end
   end

   assign push = accept && ((cmd.zeros != '0) || cmd.t0_vld || cmd.t1_vld || cmd.end_vld);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEARCH;
         win_ff   <= 16'hFFFF;
         held_ff  <= '0;
         emit_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         win_ff   <= win_in;
         held_ff  <= held_in;
         emit_ff  <= emit_in;
      end
   end

   `VSH_ASSERT(a_held_cap, clock, reset, held_ff <= CW'(HOLD_CAP))
   `VSH_ASSERT(a_held_only_in_unit, clock, reset, (held_ff != '0) |-> (phase_ff == PH_UNIT))
   `VSH_NEVER(a_push_no_valid, clock, reset, push && !req_valid)

endmodule

// ===== hw/rtl/vsh_cmd_fifo.sv =====
// Short command queue between front and back end.
// Register array with show-ahead read. Uses vsh_pkg.
`include "vc1_seq_header_extractor_defines.svh"

module vsh_cmd_fifo #(
   parameter int DEPTH = vsh_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  vsh_pkg::cmd_type       wr_data,
   input  logic                   pop,
   output vsh_pkg::cmd_type       rd_data,
   output vsh_pkg::fifo_stat_type stat
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   vsh_pkg::cmd_type mem [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff;

   function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wrap_inc(wr_ptr_ff);
         if (pop)  rd_ptr_ff <= wrap_inc(rd_ptr_ff);
         if (push && !pop)      count_ff <= count_ff + CW'(1);
         else if (pop && !push) count_ff <= count_ff - CW'(1);
      end
   end

   assign rd_data    = mem[rd_ptr_ff];
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CW'(DEPTH));

   `VSH_NEVER(a_push_full, clock, reset, push && stat.full)
   `VSH_NEVER(a_pop_empty, clock, reset, pop && stat.empty)

endmodule

// ===== hw/rtl/vsh_back.sv =====
// Back end: walks one command a result at a time into the output register.
// Uses vsh_pkg.
`include "vc1_seq_header_extractor_defines.svh"

module vsh_back (
   input  logic                   clock,
   input  logic                   reset,
   input  vsh_pkg::cmd_type       q_data,
   input  vsh_pkg::fifo_stat_type q_stat,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_out_kind,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_last_of_run
);

   vsh_pkg::cmd_type cur_ff, cur_in;
   logic             busy_ff;
   logic             out_vld_ff;
   vsh_pkg::kind_type out_kind_ff, kind_in;
   logic [7:0]       out_byte_ff, byte_in;
   logic             out_last_ff, last_in;
   logic             out_free;
   logic             fire;

   assign out_free = !out_vld_ff || !rsp_stall;
   assign fire     = busy_ff && out_free;
   assign q_pop    = !busy_ff && !q_stat.empty;

   // pick the next result in order: zero burst, literals, end marker
   always_comb begin
      cur_in  = cur_ff;
      kind_in = vsh_pkg::KIND_BYTE;
      byte_in = 8'h00;
      if (cur_ff.zeros != '0) begin
         cur_in.zeros = cur_ff.zeros - vsh_pkg::CNT_W'(1);
      end else if (cur_ff.t0_vld) begin
         cur_in.t0_vld = 1'b0;
         byte_in       = cur_ff.t0;
      end else if (cur_ff.t1_vld) begin
         cur_in.t1_vld = 1'b0;
         byte_in       = cur_ff.t1;
      end else begin
         cur_in.end_vld = 1'b0;
         kind_in        = cur_ff.end_kind;
      end
      last_in = (cur_in.zeros == '0) && !cur_in.t0_vld && !cur_in.t1_vld && !cur_in.end_vld;
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_data;
      end else if (fire) begin
         cur_ff <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_kind_ff <= kind_in;
         out_byte_ff <= byte_in;
         out_last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (q_pop)                busy_ff <= 1'b1;
         else if (fire && last_in) busy_ff <= 1'b0;
         if (fire)                 out_vld_ff <= 1'b1;
         else if (!rsp_stall)      out_vld_ff <= 1'b0;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_out_kind    = out_kind_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_last_of_run = out_last_ff;

   `VSH_ASSERT(a_marker_is_last, clock, reset,
               (out_vld_ff && out_kind_ff != vsh_pkg::KIND_BYTE) |-> out_last_ff)

endmodule
